[sv/linear_probe_hash_table_core_macros.svh]
// Assertion macros for the linear probe hash table
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/lpht_pkg.sv]
// Shared types and constants of the linear probe hash table
package lpht_pkg;
  localparam int SLOTS = 256;

  localparam logic [2:0] ST_FOUND      = 3'd0;
  localparam logic [2:0] ST_INSERTED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_ZERO_VALUE = 3'd4;

  typedef enum logic [2:0] {
    PS_CLEAR,
    PS_IDLE,
    PS_READ,
    PS_CHECK,
    PS_RESULT
  } probe_state_t;
endpackage

[sv/lpht_ram.sv]
// Generic single-port RAM with registered read
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/lpht_front.sv]
// Front end: accepts requests, classifies zero-value inserts, two-entry queue
module lpht_front
  import lpht_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic                  q_insert,
  output logic                  q_zero,
  output logic [KEY_BITS-1:0]   q_key,
  output logic [VALUE_BITS-1:0] q_value
);
  localparam int EW = 2 + KEY_BITS + VALUE_BITS;

  logic [EW-1:0] ent_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          rd_r, rd_nxt, wr_r, wr_nxt;
  logic          push, pop;
  logic [EW-1:0] head;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign head     = ent_r[rd_r];
  assign q_insert = head[EW-1];
  assign q_zero   = head[EW-2];
  assign q_key    = head[VALUE_BITS +: KEY_BITS];
  assign q_value  = head[VALUE_BITS-1:0];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= {in_operation, in_operation && (in_value == '0), in_key, in_value};
    end
  end
endmodule

[sv/lpht_back.sv]
// Back end: probe sequencer over the slot memories, result register
module lpht_back
  import lpht_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic                  q_insert,
  input  logic                  q_zero,
  input  logic [KEY_BITS-1:0]   q_key,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [31:0]           out_stored_value,
  output logic [7:0]            out_slot,
  output probe_state_t          state
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = KEY_BITS + VALUE_BITS + 1;

  probe_state_t st_r, st_nxt;
  logic [AW-1:0]         idx_r, idx_nxt, start_r, start_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic                  ins_r, ins_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  ov_r, ov_nxt;
  logic [2:0]            os_r, os_nxt;
  logic [31:0]           osv_r, osv_nxt;
  logic [7:0]            osl_r, osl_nxt;
  logic                  we;
  logic [AW-1:0]         addr;
  logic [RW-1:0]         wdata, rdata;
  logic                  hit_v;
  logic [KEY_BITS-1:0]   hit_k;
  logic [VALUE_BITS-1:0] hit_d;
  logic                  out_free;
  logic [AW-1:0]         q_start, idx_inc;

  assign {hit_v, hit_k, hit_d} = rdata;
  assign q_start  = q_key[AW-1:0];
  assign idx_inc  = (idx_r == AW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign out_free = !ov_r || out_ready;
  assign q_ready  = (st_r == PS_IDLE) && out_free;
  assign state    = st_r;

  lpht_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      PS_CLEAR:  if (idx_r == AW'(SLOTS - 1)) st_nxt = PS_IDLE;
      PS_IDLE:   if (q_valid && out_free) st_nxt = q_zero ? PS_RESULT : PS_READ;
      PS_READ:   st_nxt = PS_CHECK;
      PS_CHECK: begin
        if (!hit_v || hit_k == key_r || n_r == CW'(SLOTS - 1)) st_nxt = PS_RESULT;
        else st_nxt = PS_READ;
      end
      PS_RESULT: if (out_free) st_nxt = PS_IDLE;
      default:   st_nxt = PS_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r; start_nxt = start_r; n_nxt = n_r;
    ins_nxt = ins_r; key_nxt = key_r; val_nxt = val_r;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r; osv_nxt = osv_r; osl_nxt = osl_r;
    we = 1'b0; addr = idx_r; wdata = {1'b1, key_r, val_r};
    case (st_r)
      PS_CLEAR: begin
        we = 1'b1; wdata = '0;
        idx_nxt = idx_inc;
      end
      PS_IDLE: begin
        if (q_valid && out_free) begin
          idx_nxt = q_start; start_nxt = q_start; n_nxt = '0;
          ins_nxt = q_insert; key_nxt = q_key; val_nxt = q_value;
          os_nxt = ST_ZERO_VALUE; osv_nxt = '0;
          osl_nxt = 8'(q_start);
        end
      end
      PS_READ: ;
      PS_CHECK: begin
        osv_nxt = '0;
        osl_nxt = 8'(idx_r);
        if (!hit_v) begin
          os_nxt = ins_r ? ST_INSERTED : ST_NOT_FOUND;
          we = ins_r;
        end else if (hit_k == key_r) begin
          os_nxt = ST_FOUND;
          osv_nxt = 32'(hit_d);
        end else if (n_r == CW'(SLOTS - 1)) begin
          os_nxt = ins_r ? ST_FULL : ST_NOT_FOUND;
          osl_nxt = 8'(start_r);
        end else begin
          idx_nxt = idx_inc;
          n_nxt = n_r + 1'b1;
        end
      end
      PS_RESULT: begin
        if (out_free) ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= PS_CLEAR;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
    start_r <= start_nxt; n_r <= n_nxt; ins_r <= ins_nxt;
    key_r <= key_nxt; val_r <= val_nxt;
    os_r <= os_nxt; osv_r <= osv_nxt; osl_r <= osl_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_stored_value = osv_r;
  assign out_slot         = osl_r;
endmodule

[sv/linear_probe_hash_table_core.sv]
// Linear probe hash table top level
// A request probes slots one by one, each probe a memory read and then a compare,
// between setup and result; a zero-value insert skips probing. The single-port
// slot memory sets this sequence. After reset a clearing pass over all SLOTS slots runs
// before the first request is taken. A two-entry queue takes requests during probing.
`include "linear_probe_hash_table_core_macros.svh"
module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [31:0]           out_stored_value,
  output logic [7:0]            out_slot
);
  logic                  q_valid, q_ready, q_insert, q_zero;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_value;
  probe_state_t          state;
  logic                  out_miss;

  lpht_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_key, .in_value,
    .q_valid, .q_ready, .q_insert, .q_zero, .q_key, .q_value
  );

  lpht_back #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_insert, .q_zero, .q_key, .q_value,
    .out_valid, .out_ready, .out_status, .out_stored_value, .out_slot, .state
  );

  assign out_miss = out_valid && (out_status != ST_FOUND);

  `LPHT_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= ST_ZERO_VALUE, "status")
  `LPHT_ASSERT_IMPL(a_value_zero, clk, rst_n, out_miss, out_stored_value == '0, "nonzero value")
  `LPHT_ASSERT_IMPL(a_no_take_clear, clk, rst_n, state == PS_CLEAR, !q_ready, "taken in clear")
endmodule
